FILE: hdl/brb_pkg.sv
// Shared types and constants of the byte ring buffer with bursts.
// Used by the front, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package brb_pkg;

  // Default sizing, handed down from the top level
  localparam int RING_DEPTH_DEF = 256;
  localparam int READ_MAX_DEF   = 64;

  // Depths of the command queue and the result queue
  localparam int CMD_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 4;

  // Fixed field widths
  localparam int SIZE_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 8;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_DISCARD = 2'd2,
    ACT_STATUS  = 2'd3
  } act_t;

  // Result kinds; a queued command carries the kind of the results it makes
  typedef enum logic [2:0] {
    KIND_WR_OK   = 3'd0,
    KIND_WR_REJ  = 3'd1,
    KIND_RD_BYTE = 3'd2,
    KIND_RD_REF  = 3'd3,
    KIND_STATUS  = 3'd4,
    KIND_DISCARD = 3'd5
  } kind_t;

  // Command from the front to the back, with the state after the transaction
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic [POS_W-1:0]   slot;
    logic [COUNT_W-1:0] cnt;
    logic [POS_W-1:0]   held;
    logic [POS_W-1:0]   free;
    logic [POS_W-1:0]   rd_pos;
    logic [POS_W-1:0]   wr_pos;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [POS_W-1:0]  held;
    logic [POS_W-1:0]  free;
    logic [POS_W-1:0]  rd_pos;
    logic [POS_W-1:0]  wr_pos;
  } res_t;

  // Back sequencer states
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_READ = 1'b1
  } seq_t;

endpackage

FILE: hdl/brb_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing; width and depth come from the instantiating module.
`timescale 1ns / 1ps

module brb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = store_r[head_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PW'(DEPTH-1)) ? '0 : tail_r + PW'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == PW'(DEPTH-1)) ? '0 : head_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Store entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[tail_r] <= din;
    end
  end

endmodule

FILE: hdl/brb_front.sv
// Front end: holds the ring pointers, burst state and size register,
// classifies each accepted item into a command. Depends on brb_pkg.
`timescale 1ns / 1ps

module brb_front #(
  parameter int READ_MAX  = brb_pkg::READ_MAX_DEF,
  parameter int MEM_DEPTH = brb_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [brb_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        accept,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_burst_first,
  input  logic [7:0]                  in_burst_len,
  input  logic [6:0]                  in_min_count,
  input  logic [6:0]                  in_max_count,
  output brb_pkg::cmd_t               cmd,
  output logic [brb_pkg::SIZE_W-1:0]  eff_size
);

  localparam int SW = brb_pkg::SIZE_W;
  localparam int PW = brb_pkg::POS_W;
  localparam int CW = brb_pkg::COUNT_W;

  logic [SW-1:0] size_r;
  logic [PW-1:0] rd_slot_r, rd_slot_nxt;
  logic [PW-1:0] wr_slot_r, wr_slot_nxt;
  logic [7:0]    burst_left_r, burst_left_nxt;
  logic          burst_ref_r, burst_ref_nxt;

  logic [SW-1:0] s9, held9, free9, held_a9, free_a9;
  logic [SW-1:0] len9, base9, wr_inc9, rd_sum9;
  logic          open_burst, refused, rd_refused;
  logic [CW-1:0] lim, cnt;

  assign eff_size = s9;

  always_comb begin
    // Clamp the size register to the usable range
    if (size_r < SW'(2)) begin
      s9 = SW'(2);
    end else if (size_r > SW'(MEM_DEPTH)) begin
      s9 = SW'(MEM_DEPTH);
    end else begin
      s9 = size_r;
    end

    // Fill level before the transaction
    if (wr_slot_r >= rd_slot_r) begin
      held9 = {1'b0, wr_slot_r} - {1'b0, rd_slot_r};
    end else begin
      held9 = s9 - {1'b0, rd_slot_r} + {1'b0, wr_slot_r};
    end
    free9 = s9 - SW'(1) - held9;

    // Burst opening and length
    open_burst = in_burst_first || (burst_left_r == '0);
    if (in_burst_first) begin
      len9 = (in_burst_len == '0) ? SW'(1) : {1'b0, in_burst_len};
    end else begin
      len9 = SW'(1);
    end
    refused = open_burst ? (len9 > free9) : burst_ref_r;
    base9   = open_burst ? len9 : {1'b0, burst_left_r};
    wr_inc9 = {1'b0, wr_slot_r} + SW'(1);

    // Read length and final read slot
    lim = (in_max_count > CW'(READ_MAX)) ? CW'(READ_MAX) : in_max_count;
    rd_refused = (held9 == '0) || ({2'b0, in_min_count} > held9) || (lim == '0);
    cnt = (held9 < {2'b0, lim}) ? held9[CW-1:0] : lim;
    rd_sum9 = {1'b0, rd_slot_r} + {2'b0, cnt};

    rd_slot_nxt    = rd_slot_r;
    wr_slot_nxt    = wr_slot_r;
    burst_left_nxt = burst_left_r;
    burst_ref_nxt  = burst_ref_r;
    held_a9        = held9;

    cmd.kind = brb_pkg::KIND_STATUS;
    cmd.data = in_data_byte;
    cmd.slot = wr_slot_r;
    cmd.cnt  = cnt;

    unique case (brb_pkg::act_t'(in_action))
      brb_pkg::ACT_WRITE: begin
        burst_ref_nxt  = refused;
        burst_left_nxt = 8'(base9 - SW'(1));
        if (refused) begin
          cmd.kind = brb_pkg::KIND_WR_REJ;
        end else begin
          cmd.kind    = brb_pkg::KIND_WR_OK;
          wr_slot_nxt = (wr_inc9 >= s9) ? '0 : wr_inc9[PW-1:0];
          held_a9     = held9 + SW'(1);
        end
      end
      brb_pkg::ACT_READ: begin
        if (rd_refused) begin
          cmd.kind = brb_pkg::KIND_RD_REF;
        end else begin
          cmd.kind    = brb_pkg::KIND_RD_BYTE;
          cmd.slot    = rd_slot_r;
          rd_slot_nxt = (rd_sum9 >= s9) ? PW'(rd_sum9 - s9) : rd_sum9[PW-1:0];
          held_a9     = held9 - {2'b0, cnt};
        end
      end
      brb_pkg::ACT_DISCARD: begin
        cmd.kind    = brb_pkg::KIND_DISCARD;
        rd_slot_nxt = wr_slot_r;
        held_a9     = '0;
      end
      brb_pkg::ACT_STATUS: begin
        cmd.kind = brb_pkg::KIND_STATUS;
      end
      default: begin
        cmd.kind = brb_pkg::KIND_STATUS;
      end
    endcase

    // State after the whole transaction, carried by every result
    free_a9     = s9 - SW'(1) - held_a9;
    cmd.held    = held_a9[PW-1:0];
    cmd.free    = free_a9[PW-1:0];
    cmd.rd_pos  = rd_slot_nxt;
    cmd.wr_pos  = wr_slot_nxt;
  end

  // Update ring state; a size write empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= SW'(256);
      rd_slot_r    <= '0;
      wr_slot_r    <= '0;
      burst_left_r <= '0;
      burst_ref_r  <= 1'b0;
    end else if (cfg_we) begin
      size_r       <= cfg_data;
      rd_slot_r    <= '0;
      wr_slot_r    <= '0;
      burst_left_r <= '0;
      burst_ref_r  <= 1'b0;
    end else if (accept) begin
      rd_slot_r    <= rd_slot_nxt;
      wr_slot_r    <= wr_slot_nxt;
      burst_left_r <= burst_left_nxt;
      burst_ref_r  <= burst_ref_nxt;
    end
  end

endmodule

FILE: hdl/brb_back.sv
// Back end: owns the byte store, executes queued commands in order and
// issues one result per cycle while the out queue has room. Uses brb_pkg.
`timescale 1ns / 1ps

module brb_back #(
  parameter int MEM_DEPTH = brb_pkg::RING_DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_valid,
  input  brb_pkg::cmd_t                            cmd,
  output logic                                     cmd_pop,
  input  logic [brb_pkg::SIZE_W-1:0]               eff_size,
  input  logic [$clog2(brb_pkg::OUT_Q_DEPTH+1)-1:0] out_count,
  output logic                                     res_valid,
  output brb_pkg::res_t                            res
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SW = brb_pkg::SIZE_W;
  localparam int PW = brb_pkg::POS_W;
  localparam int CW = brb_pkg::COUNT_W;

  logic [7:0]     mem [MEM_DEPTH];
  logic [7:0]     mem_q_r;

  brb_pkg::seq_t  state_r, state_nxt;
  logic [PW-1:0]  addr_r, addr_nxt, cur_addr;
  logic [CW-1:0]  left_r, left_nxt, cur_left;
  logic [SW-1:0]  addr_inc9;
  logic           room, go, is_rd, is_last;

  logic           p_valid_r;
  brb_pkg::res_t  p_r;

  // Sequence commands; a read stays at the queue head until its last byte
  always_comb begin
    room      = (int'(out_count) + int'(p_valid_r)) < brb_pkg::OUT_Q_DEPTH;
    go        = cmd_valid && room;
    is_rd     = (cmd.kind == brb_pkg::KIND_RD_BYTE);
    cur_addr  = (state_r == brb_pkg::SEQ_READ) ? addr_r : cmd.slot;
    cur_left  = (state_r == brb_pkg::SEQ_READ) ? left_r : cmd.cnt;
    is_last   = !is_rd || (cur_left == CW'(1));
    addr_inc9 = {1'b0, cur_addr} + SW'(1);
    cmd_pop   = go && is_last;

    state_nxt = state_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    if (go && is_rd) begin
      addr_nxt  = (addr_inc9 >= eff_size) ? '0 : addr_inc9[PW-1:0];
      left_nxt  = cur_left - CW'(1);
      state_nxt = is_last ? brb_pkg::SEQ_IDLE : brb_pkg::SEQ_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    left_r <= left_nxt;
  end

  // Byte store: write accepted bytes, read one slot per issued read byte
  always_ff @(posedge clk) begin
    if (go && (cmd.kind == brb_pkg::KIND_WR_OK)) begin
      mem[cmd.slot[AW-1:0]] <= cmd.data;
    end
    if (go && is_rd) begin
      mem_q_r <= mem[cur_addr[AW-1:0]];
    end
  end

  // Hold issued result while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      p_r.kind     <= cmd.kind;
      p_r.out_byte <= '0;
      p_r.last     <= is_last;
      p_r.held     <= cmd.held;
      p_r.free     <= cmd.free;
      p_r.rd_pos   <= cmd.rd_pos;
      p_r.wr_pos   <= cmd.wr_pos;
    end
  end

  // Merge store data into read results
  always_comb begin
    res_valid = p_valid_r;
    res       = p_r;
    if (p_r.kind == brb_pkg::KIND_RD_BYTE) begin
      res.out_byte = mem_q_r;
    end
  end

endmodule

FILE: hdl/byte_ring_buffer_bursts_core.sv
// Top level of the byte ring buffer with burst writes and bounded reads.
// Depends on brb_pkg, brb_fifo, brb_front and brb_back.
`timescale 1ns / 1ps

// The block accepts one input transaction per cycle while its four-entry
// command queue has room; the front end updates the ring pointers at once.
// The back end produces one result per cycle while the result queue has
// room: a write, discard, status or refused read yields one result, and a
// read of n bytes yields n results, one byte store read per cycle. The
// first result of a transaction passes the command queue and the result
// holding register before it reaches the result queue. Results wait in a
// four-entry queue, so input keeps flowing while pop is low until the
// queues fill. A size write empties the ring and is taken at any time;
// write it only while the block is idle. No clearing pass follows reset.
module byte_ring_buffer_bursts_core #(
  parameter int RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
  parameter int READ_MAX   = brb_pkg::READ_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data,
  // Input queue side
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_burst_first,
  input  logic [7:0] in_burst_len,
  input  logic [6:0] in_min_count,
  input  logic [6:0] in_max_count,
  // Result queue side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last,
  output logic [7:0] out_held_count,
  output logic [7:0] out_free_count,
  output logic [7:0] out_rd_position,
  output logic [7:0] out_wr_position
);

  localparam int MEM_DEPTH = (RING_DEPTH < 256) ? RING_DEPTH : 256;
  localparam int CMD_W     = $bits(brb_pkg::cmd_t);
  localparam int RES_W     = $bits(brb_pkg::res_t);
  localparam int OCW       = $clog2(brb_pkg::OUT_Q_DEPTH + 1);
  localparam int CCW       = $clog2(brb_pkg::CMD_Q_DEPTH + 1);

  logic                       accept;
  logic                       cmd_full, cmd_empty, cmd_pop;
  brb_pkg::cmd_t              cmd_new, cmd_head;
  logic [CMD_W-1:0]           cmd_dout;
  logic [CCW-1:0]             cmd_count;
  logic [brb_pkg::SIZE_W-1:0] eff_size;
  logic                       res_valid, res_full;
  brb_pkg::res_t              res_new, res_head;
  logic [RES_W-1:0]           res_dout;
  logic [OCW-1:0]             out_count;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push && !cmd_full;

  // Classify accepted transactions
  brb_front #(
    .READ_MAX  (READ_MAX),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .in_burst_first (in_burst_first),
    .in_burst_len   (in_burst_len),
    .in_min_count   (in_min_count),
    .in_max_count   (in_max_count),
    .cmd            (cmd_new),
    .eff_size       (eff_size)
  );

  // Decouple front and back
  brb_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (brb_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (cmd_new),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign cmd_head = brb_pkg::cmd_t'(cmd_dout);

  // Execute commands against the byte store
  brb_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty && (cmd_count != '0)),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .eff_size  (eff_size),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res_new)
  );

  // Hold results until taken
  brb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (brb_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res_new),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty),
    .count (out_count)
  );

  assign res_head        = brb_pkg::res_t'(res_dout);
  assign out_kind        = res_head.kind;
  assign out_out_byte    = res_head.out_byte;
  assign out_last        = res_head.last;
  assign out_held_count  = res_head.held;
  assign out_free_count  = res_head.free;
  assign out_rd_position = res_head.rd_pos;
  assign out_wr_position = res_head.wr_pos;

endmodule
